[design/rrip_dip_dead_block_replacement_defines.svh]
// assertion macros used by the policy design file
`ifndef RRIP_DIP_DEAD_BLOCK_REPLACEMENT_DEFINES_SVH
`define RRIP_DIP_DEAD_BLOCK_REPLACEMENT_DEFINES_SVH

// condition holds in the same cycle
`define RDD_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// condition holds in the next cycle
`define RDD_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[design/rdd_pkg.sv]
// ----------------------------------------------------------------------------
// rdd_pkg
// types and constants of the rrip/dip dead block replacement policy
// ----------------------------------------------------------------------------
package rdd_pkg;

    localparam int NUM_SETS_DEF    = 2048;
    localparam int NUM_WAYS_DEF    = 16;
    localparam int LEADER_SETS_DEF = 32;

    localparam logic       CMD_QUERY  = 1'b0;
    localparam logic       CMD_UPDATE = 1'b1;
    localparam logic [1:0] RRPV_MAX   = 2'd3;
    localparam logic [9:0] PSEL_MID   = 10'd512;
    localparam logic [9:0] PSEL_TOP   = 10'd1023;

    typedef struct packed {
        logic        command;
        logic [10:0] set_index;
        logic [3:0]  way_index;
        logic        was_hit;
        logic [15:0] valid_mask;
        logic [3:0]  draw_ten;
        logic [4:0]  draw_thirtytwo;
    } req_t;

    typedef struct packed {
        logic [3:0] victim_way;
        logic       bypassed;
    } rsp_t;

endpackage

[design/rdd_ram.sv]
// ----------------------------------------------------------------------------
// rdd_ram
// generic simple dual port ram, one write and one registered read port
// ----------------------------------------------------------------------------
module rdd_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 2048
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

[design/rrip_dip_dead_block_replacement.sv]
// ----------------------------------------------------------------------------
// rrip_dip_dead_block_replacement
// per-set rrpv and dead bits in two rams, read-modify-write per word
// ----------------------------------------------------------------------------
// a word: ram read on acceptance, then decide and write back the set row
// no new word until the single read-modify-write of the row is done; rsp_ready can stall it
// after reset a sweep over all NUM_SETS rows sets all rrpv to 3 and dead to 0
// a non-bypassed update that wraps the 4096 counter starts a dead-bit sweep of all rows
// no word is taken during either sweep; NUM_SETS must be a power of two
module rrip_dip_dead_block_replacement #(
    parameter int NUM_SETS    = rdd_pkg::NUM_SETS_DEF,
    parameter int NUM_WAYS    = rdd_pkg::NUM_WAYS_DEF,
    parameter int LEADER_SETS = rdd_pkg::LEADER_SETS_DEF
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          req_valid,
    output logic          req_ready,
    input  rdd_pkg::req_t req,
    output logic          rsp_valid,
    input  logic          rsp_ready,
    output rdd_pkg::rsp_t rsp
);

    import rdd_pkg::*;

    `include "rrip_dip_dead_block_replacement_defines.svh"

    localparam int SET_W   = $clog2(NUM_SETS);
    localparam int WAY_W   = (NUM_WAYS > 1) ? $clog2(NUM_WAYS) : 1;
    localparam int RRPV_W  = 2 * NUM_WAYS;
    localparam int BIP_LO  = NUM_SETS / 2;
    localparam int BIP_HI  = NUM_SETS / 2 + LEADER_SETS;

    typedef enum logic [1:0] {ST_INIT, ST_IDLE, ST_COMPUTE, ST_CLEAR} state_t;

    state_t           state_reg, state_next;
    logic [SET_W-1:0] cnt_reg, cnt_next;
    logic [9:0]       psel_reg, psel_next;
    logic [11:0]      upd_cnt_reg, upd_cnt_next;
    logic             rsp_valid_reg, rsp_valid_next;
    rsp_t             rsp_reg, rsp_next;
    req_t             req_reg, req_next;

    logic              rd_en;
    logic [SET_W-1:0]  rd_addr;
    logic [RRPV_W-1:0] rrpv_rd, rrpv_wr;
    logic [NUM_WAYS-1:0] dead_rd, dead_wr;
    logic              rrpv_we, dead_we;
    logic [SET_W-1:0]  wr_addr;

    function automatic logic [WAY_W-1:0] way_mod(input logic [3:0] w);
        logic [5:0] v;
        v = {2'b00, w};
        for (int i = 0; i < 8; i++)
        begin
            if (v >= 6'(NUM_WAYS))
            begin
                v = v - 6'(NUM_WAYS);
            end
        end
        return WAY_W'(v);
    endfunction

    rdd_ram #(.WIDTH(RRPV_W), .DEPTH(NUM_SETS)) u_rrpv_ram (
        .clk     (clk),
        .wr_en   (rrpv_we),
        .wr_addr (wr_addr),
        .wr_data (rrpv_wr),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rrpv_rd)
    );

    rdd_ram #(.WIDTH(NUM_WAYS), .DEPTH(NUM_SETS)) u_dead_ram (
        .clk     (clk),
        .wr_en   (dead_we),
        .wr_addr (wr_addr),
        .wr_data (dead_wr),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (dead_rd)
    );

    assign req_ready = (state_reg == ST_IDLE);
    assign rd_en     = req_valid && req_ready;
    assign rd_addr   = SET_W'(req.set_index);
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    // decision logic on the row read for the held word
    logic [SET_W-1:0]    s;
    logic [WAY_W-1:0]    w;
    logic [31:0]         vm_ext;
    logic                inv_found, dead_found, top_found;
    logic [4:0]          inv_way, dead_way, top_way;
    logic [1:0]          top, add, ins;
    logic                lip_lead, bip_lead, use_lip, bypass, fire;
    logic [RRPV_W-1:0]   rrpv_aged, rrpv_upd;
    logic [NUM_WAYS-1:0] dead_upd;
    logic [11:0]         cnt_inc;

    always_comb
    begin
        s        = SET_W'(req_reg.set_index);
        w        = way_mod(req_reg.way_index);
        vm_ext   = {16'hFFFF, req_reg.valid_mask};
        lip_lead = ({1'b0, s} < (SET_W+1)'(LEADER_SETS));
        bip_lead = ({1'b0, s} >= (SET_W+1)'(BIP_LO)) && ({1'b0, s} < (SET_W+1)'(BIP_HI));

        inv_found  = 1'b0;
        inv_way    = '0;
        dead_found = 1'b0;
        dead_way   = '0;
        top        = '0;
        for (int i = 0; i < NUM_WAYS; i++)
        begin
            if (!inv_found && !vm_ext[i])
            begin
                inv_found = 1'b1;
                inv_way   = 5'(i);
            end
            if (!dead_found && dead_rd[i])
            begin
                dead_found = 1'b1;
                dead_way   = 5'(i);
            end
            if (rrpv_rd[2*i +: 2] > top)
            begin
                top = rrpv_rd[2*i +: 2];
            end
        end
        // aging lifts every way by the gap, the first way at the max lands on 3
        add       = RRPV_MAX - top;
        top_found = 1'b0;
        top_way   = '0;
        rrpv_aged = rrpv_rd;
        for (int i = 0; i < NUM_WAYS; i++)
        begin
            rrpv_aged[2*i +: 2] = rrpv_rd[2*i +: 2] + add;
            if (!top_found && rrpv_rd[2*i +: 2] == top)
            begin
                top_found = 1'b1;
                top_way   = 5'(i);
            end
        end

        if (lip_lead)
        begin
            use_lip = 1'b1;
        end
        else if (bip_lead)
        begin
            use_lip = 1'b0;
        end
        else
        begin
            use_lip = (psel_reg < PSEL_MID);
        end

        bypass = !req_reg.was_hit && (req_reg.draw_ten == 4'd0);
        if (!req_reg.was_hit || use_lip || req_reg.draw_thirtytwo != 5'd0)
        begin
            ins = RRPV_MAX;
        end
        else
        begin
            ins = 2'd0;
        end
        rrpv_upd              = rrpv_rd;
        rrpv_upd[2*w +: 2]    = ins;
        dead_upd              = dead_rd;
        dead_upd[w]           = bypass;
        cnt_inc               = upd_cnt_reg + 12'd1;
    end

    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        psel_next      = psel_reg;
        upd_cnt_next   = upd_cnt_reg;
        rsp_valid_next = rsp_valid_reg && !rsp_ready;
        rsp_next       = rsp_reg;
        req_next       = req_reg;
        rrpv_we        = 1'b0;
        dead_we        = 1'b0;
        wr_addr        = s;
        rrpv_wr        = rrpv_upd;
        dead_wr        = dead_upd;
        fire           = 1'b0;

        case (state_reg)
            ST_INIT, ST_CLEAR:
            begin
                wr_addr = cnt_reg;
                rrpv_wr = '1;
                dead_wr = '0;
                rrpv_we = (state_reg == ST_INIT);
                dead_we = 1'b1;
                cnt_next = cnt_reg + SET_W'(1);
                if (cnt_reg == SET_W'(NUM_SETS - 1))
                begin
                    cnt_next   = '0;
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (rd_en)
                begin
                    req_next   = req;
                    state_next = ST_COMPUTE;
                end
            end
            ST_COMPUTE:
            begin
                fire = !rsp_valid_reg || rsp_ready;
                if (fire)
                begin
                    rsp_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                    if (req_reg.command == CMD_QUERY)
                    begin
                        rsp_next.bypassed = 1'b0;
                        if (inv_found)
                        begin
                            rsp_next.victim_way = 4'(inv_way);
                        end
                        else if (dead_found)
                        begin
                            rsp_next.victim_way = 4'(dead_way);
                        end
                        else
                        begin
                            rsp_next.victim_way = 4'(top_way);
                            rrpv_wr = rrpv_aged;
                            rrpv_we = 1'b1;
                        end
                    end
                    else
                    begin
                        rsp_next.victim_way = '0;
                        rsp_next.bypassed   = bypass;
                        upd_cnt_next        = cnt_inc;
                        dead_we             = 1'b1;
                        rrpv_we             = !bypass;
                        if (!bypass)
                        begin
                            if (req_reg.was_hit && lip_lead && psel_reg != PSEL_TOP)
                            begin
                                psel_next = psel_reg + 10'd1;
                            end
                            else if (req_reg.was_hit && !lip_lead && bip_lead
                                     && psel_reg != 10'd0)
                            begin
                                psel_next = psel_reg - 10'd1;
                            end
                            if (cnt_inc == 12'd0)
                            begin
                                state_next = ST_CLEAR;
                            end
                        end
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_INIT;
            cnt_reg       <= '0;
            psel_reg      <= PSEL_MID;
            upd_cnt_reg   <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            psel_reg      <= psel_next;
            upd_cnt_reg   <= upd_cnt_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rsp_reg <= rsp_next;
        req_reg <= req_next;
    end

    `RDD_ASSERT_NEXT(a_accept_to_compute, clk, rst_n, rd_en, state_reg == ST_COMPUTE,
        "accepted word did not move to compute")
    `RDD_ASSERT_SAME(a_no_write_idle, clk, rst_n, state_reg == ST_IDLE,
        !rrpv_we && !dead_we, "ram written while idle")
    `RDD_ASSERT_NEXT(a_rsp_from_compute, clk, rst_n, !rsp_valid_reg && state_reg != ST_COMPUTE,
        !rsp_valid_reg, "result word appeared without compute")
    `RDD_ASSERT_SAME(a_sweep_blocks, clk, rst_n, state_reg == ST_INIT || state_reg == ST_CLEAR,
        !req_ready && dead_we, "word taken or dead row not cleared during sweep")

endmodule

[tb/sv/rrip_dip_dead_block_replacement_test.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// rrip_dip_dead_block_replacement_test
// drives victim queries and replacement updates through the valid/ready
// channels, predicts each response from a local model of the rrpv, dead bits,
// selector and update counter, and compares every response word in order
// ----------------------------------------------------------------------------
module rrip_dip_dead_block_replacement_test;
    import rdd_pkg::*;

    localparam int SETS  = NUM_SETS_DEF;
    localparam int WAYS  = NUM_WAYS_DEF;
    localparam int LEADS = LEADER_SETS_DEF;

    logic clk;
    logic rst_n;
    logic req_valid;
    logic req_ready;
    req_t req;
    logic rsp_valid;
    logic rsp_ready;
    rsp_t rsp;

    rrip_dip_dead_block_replacement dut (
        .clk(clk), .rst_n(rst_n),
        .req_valid(req_valid), .req_ready(req_ready), .req(req),
        .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp(rsp)
    );

    logic [1:0]  rrpv_mdl [SETS*WAYS];
    logic        dead_mdl [SETS*WAYS];
    logic [9:0]  psel_mdl;
    logic [11:0] upd_count_mdl;
    rsp_t        pending_rsp [$];
    int          errors = 0;

    initial clk = 1'b0;
    always #10 clk = ~clk;

    initial
    begin
        #400ms;
        $display("rrip_dip_dead_block_replacement: mismatch");
        $finish;
    end

    function automatic rsp_t predict_policy(req_t r);
        rsp_t        o;
        int          s;
        int          w;
        int          base;
        int          idx;
        logic [1:0]  top;
        logic [1:0]  add;
        logic        lip_lead;
        logic        bip_lead;
        logic        use_lip;
        o = '0;
        s = r.set_index % SETS;
        base = s * WAYS;
        if (r.command == CMD_QUERY)
        begin
            for (w = 0; w < WAYS; w++)
                if (w < 16 && !r.valid_mask[w]) return '{victim_way: w[3:0], bypassed: 1'b0};
            for (w = 0; w < WAYS; w++)
                if (dead_mdl[base+w]) return '{victim_way: w[3:0], bypassed: 1'b0};
            top = '0;
            for (w = 0; w < WAYS; w++)
                if (rrpv_mdl[base+w] > top) top = rrpv_mdl[base+w];
            if (top < RRPV_MAX)
            begin
                add = RRPV_MAX - top;
                for (w = 0; w < WAYS; w++) rrpv_mdl[base+w] = rrpv_mdl[base+w] + add;
            end
            for (w = 0; w < WAYS; w++)
                if (rrpv_mdl[base+w] == RRPV_MAX) return '{victim_way: w[3:0], bypassed: 1'b0};
            return o;
        end
        idx = base + (r.way_index % WAYS);
        lip_lead = s < LEADS;
        bip_lead = s >= SETS/2 && s < SETS/2 + LEADS;
        upd_count_mdl = upd_count_mdl + 12'd1;
        if (r.was_hit)
        begin
            dead_mdl[idx] = 1'b0;
            rrpv_mdl[idx] = 2'd0;
        end
        else
            dead_mdl[idx] = 1'b1;
        use_lip = lip_lead ? 1'b1 : bip_lead ? 1'b0 : (psel_mdl < PSEL_MID);
        if (dead_mdl[idx])
        begin
            if (r.draw_ten == 4'd0)
            begin
                o.bypassed = 1'b1;
                return o;
            end
            rrpv_mdl[idx] = RRPV_MAX;
        end
        else if (use_lip)
            rrpv_mdl[idx] = RRPV_MAX;
        else
            rrpv_mdl[idx] = (r.draw_thirtytwo == 5'd0) ? 2'd0 : RRPV_MAX;
        dead_mdl[idx] = 1'b0;
        if (lip_lead && r.was_hit && psel_mdl < PSEL_TOP) psel_mdl = psel_mdl + 10'd1;
        else if (!lip_lead && bip_lead && r.was_hit && psel_mdl > 10'd0)
            psel_mdl = psel_mdl - 10'd1;
        if (upd_count_mdl == 12'd0)
            foreach (dead_mdl[i]) dead_mdl[i] = 1'b0;
        return o;
    endfunction

    // valid stays high into the next word when there is no gap
    task automatic send_word(req_t r);
        int gap;
        gap = $urandom_range(0, 15);
        if ($urandom_range(0, 3) == 0) gap = 0;
        if (gap != 0)
        begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        pending_rsp.push_back(predict_policy(r));
        req_valid <= 1'b1;
        req <= r;
        do @(posedge clk); while (!req_ready);
    endtask

    task automatic end_words();
        req_valid <= 1'b0;
    endtask

    // response side: random stall per word, then compare
    initial
    begin
        int   stall;
        rsp_t exp_rsp;
        rsp_ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            stall = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 15);
            if (stall != 0)
            begin
                rsp_ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            rsp_ready <= 1'b1;
            do @(posedge clk); while (!rsp_valid);
            if (pending_rsp.size() == 0)
            begin
                $error("unexpected response word");
                errors++;
            end
            else
            begin
                exp_rsp = pending_rsp.pop_front();
                if (rsp.victim_way !== exp_rsp.victim_way)
                begin
                    $error("victim_way expected %0d actual %0d", exp_rsp.victim_way,
                           rsp.victim_way);
                    errors++;
                end
                if (rsp.bypassed !== exp_rsp.bypassed)
                begin
                    $error("bypassed expected %0d actual %0d", exp_rsp.bypassed, rsp.bypassed);
                    errors++;
                end
            end
        end
    end

    function automatic req_t make_word(logic c, int s, int w, int h, int m, int d10, int d32);
        req_t r;
        r.command = c;
        r.set_index = s[10:0];
        r.way_index = w[3:0];
        r.was_hit = h[0];
        r.valid_mask = m[15:0];
        r.draw_ten = d10[3:0];
        r.draw_thirtytwo = d32[4:0];
        return r;
    endfunction

    task automatic wait_drain();
        while (pending_rsp.size() != 0) @(posedge clk);
    endtask

    task automatic test_directed();
        send_word(make_word(CMD_QUERY, 0, 0, 0, 16'hFFFF, 0, 0));
        send_word(make_word(CMD_QUERY, 2047, 15, 1, 16'hFFFE, 15, 31));
        send_word(make_word(CMD_QUERY, 5, 0, 0, 16'h7FFF, 0, 0));
        send_word(make_word(CMD_QUERY, 5, 0, 0, 16'h0000, 0, 0));
        send_word(make_word(CMD_UPDATE, 5, 3, 1, 16'hFFFF, 5, 7));
        send_word(make_word(CMD_UPDATE, 5, 4, 0, 16'hFFFF, 0, 0));
        send_word(make_word(CMD_QUERY, 5, 0, 0, 16'hFFFF, 0, 0));
        send_word(make_word(CMD_UPDATE, 5, 4, 0, 16'hFFFF, 9, 0));
        send_word(make_word(CMD_UPDATE, 3, 0, 1, 16'hFFFF, 15, 31));
        send_word(make_word(CMD_UPDATE, 1024, 15, 1, 16'hFFFF, 12, 0));
        send_word(make_word(CMD_UPDATE, 1055, 2, 1, 16'hFFFF, 1, 0));
        send_word(make_word(CMD_UPDATE, 1056, 2, 0, 16'hFFFF, 10, 17));
        send_word(make_word(CMD_QUERY, 1024, 0, 0, 16'hFFFF, 0, 0));
        send_word(make_word(CMD_QUERY, 2047, 0, 0, 16'hFFFF, 0, 0));
        send_word(make_word(CMD_UPDATE, 31, 8, 1, 16'hAAAA, 0, 31));
        send_word(make_word(CMD_QUERY, 31, 0, 0, 16'hFFFF, 0, 0));
    endtask

    // hits in leaders drive the selector toward both rails
    task automatic test_selector_rails();
        repeat (60) send_word(make_word(CMD_UPDATE, $urandom_range(1024, 1055),
                          $urandom_range(0, 15), 1, $urandom, 1, $urandom_range(0, 31)));
        repeat (40) send_word(make_word(CMD_QUERY, $urandom_range(1536, 1543), 0, 0,
                          16'hFFFF, 0, 0));
        repeat (120) send_word(make_word(CMD_UPDATE, $urandom_range(0, 31),
                           $urandom_range(0, 15), 1, $urandom, 1, 0));
    endtask

    task automatic test_random(int n);
        req_t r;
        int   hot;
        repeat (n)
        begin
            hot = $urandom_range(0, 7);
            r.command = 1'($urandom_range(0, 1));
            r.way_index = 4'($urandom_range(0, 15));
            r.was_hit = 1'($urandom_range(0, 1));
            r.draw_thirtytwo = 5'($urandom_range(0, 31));
            r.set_index = (hot < 5) ? 11'($urandom_range(0, 7) * 256 + $urandom_range(0, 3))
                                    : 11'($urandom_range(0, 2047));
            r.valid_mask = ($urandom_range(0, 3) != 0) ? 16'hFFFF : 16'($urandom);
            r.draw_ten = ($urandom_range(0, 2) == 0) ? 4'($urandom_range(0, 15))
                                                     : 4'($urandom_range(0, 9));
            if ($urandom_range(0, 2) != 0) r.draw_thirtytwo = 5'($urandom_range(0, 1));
            send_word(r);
        end
    endtask

    initial
    begin
        rst_n = 1'b0;
        req_valid = 1'b0;
        req = '0;
        foreach (rrpv_mdl[i]) rrpv_mdl[i] = RRPV_MAX;
        foreach (dead_mdl[i]) dead_mdl[i] = 1'b0;
        psel_mdl = PSEL_MID;
        upd_count_mdl = '0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        test_directed();
        end_words();
        wait_drain();
        test_selector_rails();
        test_random(1600);
        end_words();
        wait_drain();
        repeat (3 * SETS) @(posedge clk);
        if (errors == 0)
            $display("rrip_dip_dead_block_replacement: match");
        else
            $display("rrip_dip_dead_block_replacement: mismatch");
        $finish;
    end
endmodule
